/* rtl/sorted_table_binary_search_defines.svh */
// assertion macros for the sorted table binary search block
// used by the controller and datapath; expects clk and rst_n in scope
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define STBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/stbs_pkg.sv */
// shared constants and controller/datapath types for the binary search block
// no dependencies
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int DATA_W      = 32;
    localparam int INDEX_W     = 10;
    localparam int SIZE_W      = 11;
    localparam int PROBE_W     = 4;
    // window bounds: low up to TABLE_DEPTH, high down to -1
    localparam int WIN_W       = ADDR_W + 2;
    localparam int MAX_PROBES  = ADDR_W + 1;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic init;
        logic issue;
        logic step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic hit;
        logic next_empty;
        logic out_free;
    } dp_sts_t;

endpackage

/* rtl/stbs_if.sv */
// valid/ready channel interfaces: request, response and configuration write
// depends on stbs_pkg
interface stbs_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic [stbs_pkg::INDEX_W-1:0]         entry_index;
    logic signed [stbs_pkg::DATA_W-1:0]   entry_value;
    logic signed [stbs_pkg::DATA_W-1:0]   search_key;

    modport source (output valid, command, entry_index, entry_value, search_key,
                    input ready);
    modport sink   (input valid, command, entry_index, entry_value, search_key,
                    output ready);
endinterface

interface stbs_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [stbs_pkg::SIZE_W-1:0]    position;
    logic [stbs_pkg::PROBE_W-1:0]   probe_count;

    modport source (output valid, found, position, probe_count, input ready);
    modport sink   (input valid, found, position, probe_count, output ready);
endinterface

interface stbs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [stbs_pkg::SIZE_W-1:0]    table_size;

    modport source (output valid, table_size, input ready);
    modport sink   (input valid, table_size, output ready);
endinterface

/* rtl/stbs_ram.sv */
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/stbs_ctrl.sv */
// search sequencer: accepts items and steps the datapath through the probes
// depends on stbs_pkg and the assertion macros
`include "sorted_table_binary_search_defines.svh"

module stbs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_command,
    output logic              req_ready,
    input  stbs_pkg::dp_sts_t sts,
    output stbs_pkg::dp_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid && req_command == stbs_pkg::CMD_SEARCH)
                begin
                    cmd.init   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.issue  = !sts.empty;
                state_next = sts.empty ? ST_DONE : ST_PROBE;
            end
            ST_PROBE:
            begin
                cmd.step = 1'b1;
                if (sts.hit || sts.next_empty)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                cmd.emit = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `STBS_ASSERT_NOW(a_emit_needs_room, cmd.emit, sts.out_free,
        "result emitted while output register still holds an untaken result")

endmodule

/* rtl/stbs_dp.sv */
// datapath: table ram, search window, key compare, size register, output register
// depends on stbs_pkg, stbs_ram and the assertion macros
`include "sorted_table_binary_search_defines.svh"

module stbs_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_accept,
    input  logic                                req_command,
    input  logic [stbs_pkg::INDEX_W-1:0]        req_entry_index,
    input  logic signed [stbs_pkg::DATA_W-1:0]  req_entry_value,
    input  logic signed [stbs_pkg::DATA_W-1:0]  req_search_key,
    input  logic                                cfg_valid,
    input  logic [stbs_pkg::SIZE_W-1:0]         cfg_table_size,
    input  stbs_pkg::dp_cmd_t                   cmd,
    output stbs_pkg::dp_sts_t                   sts,
    input  logic                                rsp_ready,
    output logic                                rsp_valid,
    output logic                                rsp_found,
    output logic [stbs_pkg::SIZE_W-1:0]         rsp_position,
    output logic [stbs_pkg::PROBE_W-1:0]        rsp_probe_count
);

    localparam logic signed [stbs_pkg::WIN_W-1:0] WIN_ONE = stbs_pkg::WIN_W'(1);
    localparam logic [stbs_pkg::SIZE_W-1:0] DEPTH_SZ =
        stbs_pkg::SIZE_W'(stbs_pkg::TABLE_DEPTH);

    logic [stbs_pkg::SIZE_W-1:0]         table_size_reg;
    logic [stbs_pkg::SIZE_W-1:0]         n_sat;
    logic signed [stbs_pkg::WIN_W-1:0]   lo_reg;
    logic signed [stbs_pkg::WIN_W-1:0]   hi_reg;
    logic [stbs_pkg::ADDR_W-1:0]         mid_reg;
    logic signed [stbs_pkg::DATA_W-1:0]  key_reg;
    logic [stbs_pkg::PROBE_W-1:0]        probes_reg;
    logic                                found_reg;
    logic [stbs_pkg::SIZE_W-1:0]         pos_reg;
    logic                                rsp_valid_reg;
    logic                                rsp_found_reg;
    logic [stbs_pkg::SIZE_W-1:0]         rsp_position_reg;
    logic [stbs_pkg::PROBE_W-1:0]        rsp_probe_count_reg;

    logic signed [stbs_pkg::WIN_W-1:0]   win_sum;
    logic [stbs_pkg::ADDR_W-1:0]         mid_cur;
    logic signed [stbs_pkg::WIN_W-1:0]   mid_ext;
    logic signed [stbs_pkg::WIN_W-1:0]   lo_new;
    logic signed [stbs_pkg::WIN_W-1:0]   hi_new;
    logic signed [stbs_pkg::WIN_W-1:0]   sum_new;
    logic [stbs_pkg::ADDR_W-1:0]         mid_new;
    logic [stbs_pkg::DATA_W-1:0]         ram_rdata;
    logic signed [stbs_pkg::DATA_W-1:0]  entry;
    logic                                hit;
    logic                                less;
    logic                                ram_we;
    logic [stbs_pkg::ADDR_W-1:0]         ram_raddr;

    // size register, writes are always taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= '0;
        end
        else if (cfg_valid)
        begin
            table_size_reg <= cfg_table_size;
        end
    end

    assign n_sat = (table_size_reg > DEPTH_SZ) ? DEPTH_SZ : table_size_reg;

    assign ram_we = req_accept && req_command == stbs_pkg::CMD_LOAD &&
                    32'(req_entry_index) < stbs_pkg::TABLE_DEPTH;

    stbs_ram #(
        .WIDTH (stbs_pkg::DATA_W),
        .DEPTH (stbs_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req_entry_index[stbs_pkg::ADDR_W-1:0]),
        .wdata (req_entry_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // window arithmetic; bounds are non-negative whenever a probe is made
    always_comb
    begin
        win_sum = lo_reg + hi_reg;
        mid_cur = win_sum[stbs_pkg::ADDR_W:1];
        mid_ext = signed'(stbs_pkg::WIN_W'(mid_reg));
        entry   = signed'(ram_rdata);
        hit     = entry == key_reg;
        less    = entry < key_reg;
        lo_new  = less ? mid_ext + WIN_ONE : lo_reg;
        hi_new  = less ? hi_reg : mid_ext - WIN_ONE;
        sum_new = lo_new + hi_new;
        mid_new = sum_new[stbs_pkg::ADDR_W:1];
        // next probe address goes straight to the ram
        ram_raddr = cmd.issue ? mid_cur : mid_new;
    end

    assign sts.empty      = lo_reg > hi_reg;
    assign sts.hit        = hit;
    assign sts.next_empty = lo_new > hi_new;
    assign sts.out_free   = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            lo_reg     <= '0;
            hi_reg     <= signed'(stbs_pkg::WIN_W'(n_sat)) - WIN_ONE;
            key_reg    <= req_search_key;
            probes_reg <= '0;
            found_reg  <= 1'b0;
            pos_reg    <= '0;
        end
        else if (cmd.issue)
        begin
            mid_reg <= mid_cur;
        end
        else if (cmd.step)
        begin
            probes_reg <= probes_reg + 1'b1;
            found_reg  <= hit;
            pos_reg    <= hit ? stbs_pkg::SIZE_W'(mid_reg) : lo_new[stbs_pkg::SIZE_W-1:0];
            lo_reg     <= lo_new;
            hi_reg     <= hi_new;
            mid_reg    <= mid_new;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_found_reg       <= found_reg;
            rsp_position_reg    <= pos_reg;
            rsp_probe_count_reg <= probes_reg;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp_found       = rsp_found_reg;
    assign rsp_position    = rsp_position_reg;
    assign rsp_probe_count = rsp_probe_count_reg;

    `STBS_ASSERT_NOW(a_probe_in_window, cmd.step,
        lo_reg <= mid_ext && mid_ext <= hi_reg,
        "probe address outside the search window")
    `STBS_ASSERT_NEXT(a_window_shrinks, cmd.step && !hit && !sts.next_empty,
        (hi_reg - lo_reg) < $past(hi_reg - lo_reg),
        "search window did not shrink after a miss")
    `STBS_ASSERT_NOW(a_probe_limit, cmd.step,
        probes_reg < stbs_pkg::PROBE_W'(stbs_pkg::MAX_PROBES),
        "search ran past the maximum number of probes")
    `STBS_ASSERT_NOW(a_hit_in_range, cmd.emit && found_reg, pos_reg < n_sat,
        "match reported beyond the table size")

endmodule

/* rtl/sorted_table_binary_search.sv */
// Sorted table binary search, top level.
// Channels (valid/ready, transfer on a clock edge with both high):
//   req - command 0 loads entry_value into slot entry_index, command 1 searches
//         for search_key over the first table_size slots
//   rsp - one result per search: found, position (match index or insertion
//         point) and probe_count; loads give no result
//   cfg - writes table_size, always ready; write only while the block is idle
// A load is written to the table ram when taken and req stays ready. A search
// holds req not ready through setup, a probe state per probe (at most 11
// probes, none for an empty table) and a done state that moves its result
// into the output register once that is free. Each probe is one read of the
// simple dual-port table ram, with compare and next address in the same cycle.
// A finished result sits in the output register while the next item is taken;
// if rsp is still stalled when the next search completes, that search waits.
// Reset clears the control state and table_size; table contents stay
// undefined until loaded.
// Depends on stbs_pkg, the channel interfaces, stbs_ctrl and stbs_dp.
module sorted_table_binary_search (
    input  logic           clk,
    input  logic           rst_n,
    stbs_req_if.sink       req,
    stbs_rsp_if.source     rsp,
    stbs_cfg_if.sink       cfg
);

    stbs_pkg::dp_cmd_t cmd;
    stbs_pkg::dp_sts_t sts;
    logic              req_ready;
    logic              req_accept;

    assign req.ready  = req_ready;
    assign req_accept = req.valid && req_ready;
    assign cfg.ready  = 1'b1;

    stbs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .req_ready   (req_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    stbs_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_accept      (req_accept),
        .req_command     (req.command),
        .req_entry_index (req.entry_index),
        .req_entry_value (req.entry_value),
        .req_search_key  (req.search_key),
        .cfg_valid       (cfg.valid),
        .cfg_table_size  (cfg.table_size),
        .cmd             (cmd),
        .sts             (sts),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_found       (rsp.found),
        .rsp_position    (rsp.position),
        .rsp_probe_count (rsp.probe_count)
    );

endmodule

/* test/tb_top.sv */
// self-checking testbench for sorted_table_binary_search: loads, table_size writes and
// searches with random gaps on both channels, results checked against a software mirror
// depends on stbs_pkg, the channel interfaces in stbs_if and the block itself
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 1900;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_SEARCHES = 30;

    localparam logic signed [stbs_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [stbs_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic                         found;
        logic [stbs_pkg::SIZE_W-1:0]  position;
        logic [stbs_pkg::PROBE_W-1:0] probe_count;
    } search_answer_t;

    class search_scoreboard_t;
        logic signed [stbs_pkg::DATA_W-1:0] entries [stbs_pkg::TABLE_DEPTH];
        logic [stbs_pkg::SIZE_W-1:0]        table_size;
        search_answer_t                     pending_answers [$];
        int                                 errors;

        function new();
            table_size = '0;
            errors     = 0;
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction

        // binary search over the mirrored table, floor midpoint, stop on first equal
        function search_answer_t lookup(logic signed [stbs_pkg::DATA_W-1:0] key);
            search_answer_t ans;
            int n, lo, hi, mid, probes;
            bit hit;
            n = (table_size > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH
                                                     : int'(table_size);
            lo = 0;
            hi = n - 1;
            mid = 0;
            probes = 0;
            hit = 1'b0;
            while (lo <= hi && !hit)
            begin
                mid = (lo + hi) / 2;
                probes++;
                if (entries[mid] == key)
                    hit = 1'b1;
                else if (entries[mid] < key)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
            ans.found       = hit;
            ans.position    = hit ? stbs_pkg::SIZE_W'(mid) : stbs_pkg::SIZE_W'(lo);
            ans.probe_count = stbs_pkg::PROBE_W'(probes);
            return ans;
        endfunction

        function void note_item(logic cmd, logic [stbs_pkg::INDEX_W-1:0] idx,
                                logic signed [stbs_pkg::DATA_W-1:0] val,
                                logic signed [stbs_pkg::DATA_W-1:0] key);
            if (cmd == stbs_pkg::CMD_LOAD)
                entries[idx] = val;
            else
                pending_answers.push_back(lookup(key));
        endfunction

        task report(string msg);
            $display("%0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic found, logic [stbs_pkg::SIZE_W-1:0] position,
                          logic [stbs_pkg::PROBE_W-1:0] probe_count);
            search_answer_t want;
            if (pending_answers.size() == 0)
            begin
                report($sformatf("result with no search pending: found=%0b position=%0d probes=%0d",
                                 found, position, probe_count));
                return;
            end
            want = pending_answers.pop_front();
            if (found !== want.found)
                report($sformatf("found %0b, want %0b", found, want.found));
            if (position !== want.position)
                report($sformatf("position %0d, want %0d", position, want.position));
            if (probe_count !== want.probe_count)
                report($sformatf("probe_count %0d, want %0d", probe_count, want.probe_count));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    stbs_req_if req_ch ();
    stbs_rsp_if rsp_ch ();
    stbs_cfg_if cfg_ch ();

    sorted_table_binary_search dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    search_scoreboard_t sb = new();

    int send_idle;
    int recv_stall;
    int items_sent;
    bit full_loaded;

    always #1 clk = ~clk;

    initial
    begin
        #1ms;
        $display("sorted_table_binary_search: mismatch");
        $finish;
    end

    // result side: check on each transfer, then draw ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.found, rsp_ch.position, rsp_ch.probe_count);
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    function automatic void set_idle(idle_mode_t m);
        case (m)
            IDLE_NONE: begin send_idle = 0;  recv_stall = 0;  end
            IDLE_SEND: begin send_idle = 47; recv_stall = 0;  end
            IDLE_RECV: begin send_idle = 0;  recv_stall = 47; end
            default:   begin send_idle = 18; recv_stall = 18; end
        endcase
    endfunction

    // valid stays high after a transfer; the next call either idles or replaces the payload
    task automatic put_item(logic cmd, logic [stbs_pkg::INDEX_W-1:0] idx,
                            logic signed [stbs_pkg::DATA_W-1:0] val,
                            logic signed [stbs_pkg::DATA_W-1:0] key);
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= cmd;
        req_ch.entry_index <= idx;
        req_ch.entry_value <= val;
        req_ch.search_key  <= key;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_item(cmd, idx, val, key);
        items_sent++;
    endtask

    task automatic load_entry(logic [stbs_pkg::INDEX_W-1:0] idx,
                              logic signed [stbs_pkg::DATA_W-1:0] val);
        put_item(stbs_pkg::CMD_LOAD, idx, val, $urandom());
    endtask

    task automatic search(logic signed [stbs_pkg::DATA_W-1:0] key);
        put_item(stbs_pkg::CMD_SEARCH, stbs_pkg::INDEX_W'($urandom()), $urandom(), key);
    endtask

    // only while idle: drain results, let a trailing load finish, then write
    task automatic write_size(logic [stbs_pkg::SIZE_W-1:0] v);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.table_size <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        sb.table_size = v;
    endtask

    // fills slots 0..n-1, ascending with duplicates unless ordered is 0
    task automatic fill_table(int n, bit ordered);
        longint v, stride;
        int i;
        if ($urandom_range(0, 3) == 0)
        begin
            // dense values around zero, many duplicates
            stride = 3;
            v = longint'($urandom_range(0, 40)) - 20;
        end
        else
        begin
            stride = (longint'(1) << 32) / (n + 1);
            v = longint'(VAL_MIN) + longint'($urandom_range(0, 32'(stride)));
        end
        for (i = 0; i < n; i++)
        begin
            if (i > 0)
                v += longint'($urandom_range(0, 32'(stride)));
            if (v > longint'(VAL_MAX))
                v = longint'(VAL_MAX);
            if (ordered)
                load_entry(stbs_pkg::INDEX_W'(i), stbs_pkg::DATA_W'(v));
            else
                load_entry(stbs_pkg::INDEX_W'(i), $urandom());
        end
    endtask

    function automatic logic signed [stbs_pkg::DATA_W-1:0] pick_key();
        int n, r;
        logic signed [stbs_pkg::DATA_W-1:0] e;
        n = (sb.table_size > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH
                                                    : int'(sb.table_size);
        r = $urandom_range(0, 99);
        if (n == 0 || r < 15)
            return $urandom();
        if (r < 25)
        begin
            case ($urandom_range(0, 2))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                default: return '0;
            endcase
        end
        e = sb.entries[$urandom_range(0, n - 1)];
        if (r < 65)
            return e;
        if (r < 80)
            return e + 1;
        return e - 1;
    endfunction

    // small tables are reloaded before use so no search reaches an unwritten slot
    task automatic run_phase(idle_mode_t m);
        int n, r, count, i;
        set_idle(m);
        r = $urandom_range(0, 9);
        if (r == 0)
            n = 0;
        else if (r == 1 && full_loaded)
            n = $urandom_range(1, stbs_pkg::TABLE_DEPTH);
        else
            n = $urandom_range(1, 40);
        if (n > 0 && n <= 40)
            fill_table(n, $urandom_range(0, 7) != 0);
        write_size(stbs_pkg::SIZE_W'(n));
        count = $urandom_range(15, 35);
        for (i = 0; i < count; i++)
        begin
            // occasional stray load between searches, may break the ordering
            if ($urandom_range(0, 11) == 0)
                put_item(stbs_pkg::CMD_LOAD, stbs_pkg::INDEX_W'($urandom()), $urandom(),
                         $urandom());
            else
                search(pick_key());
        end
    endtask

    initial
    begin
        logic signed [stbs_pkg::DATA_W-1:0] directed_vals [8];
        logic signed [stbs_pkg::DATA_W-1:0] directed_keys [8];
        int i, k, phase;

        directed_vals = '{VAL_MIN, -32'sd5, 32'sd0, 32'sd3, 32'sd3, 32'sd7, 32'sd100, VAL_MAX};
        directed_keys = '{VAL_MIN, VAL_MAX, 32'sd3, -32'sd6, 32'sd1, 32'sd50,
                          VAL_MAX - 1, VAL_MIN + 1};
        items_sent  = 0;
        full_loaded = 1'b0;
        set_idle(IDLE_NONE);

        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.command     <= stbs_pkg::CMD_LOAD;
        req_ch.entry_index <= '0;
        req_ch.entry_value <= '0;
        req_ch.search_key  <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.table_size  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty table straight out of reset
        search('0);
        search(VAL_MIN);

        for (i = 0; i < 8; i++)
            load_entry(stbs_pkg::INDEX_W'(i), directed_vals[i]);
        write_size(stbs_pkg::SIZE_W'(8));
        for (i = 0; i < 8; i++)
            search(directed_keys[i]);
        write_size(stbs_pkg::SIZE_W'(1));
        search(VAL_MIN);
        search(32'sd5);

        for (phase = 0; phase < 4; phase++)
            run_phase(idle_mode_t'(phase));

        // whole table, then full, oversized and large sizes
        set_idle(IDLE_BOTH);
        fill_table(stbs_pkg::TABLE_DEPTH, 1'b1);
        full_loaded = 1'b1;
        for (k = 0; k < 4; k++)
        begin
            set_idle(idle_mode_t'(k));
            case (k)
                0:       write_size(stbs_pkg::SIZE_W'(stbs_pkg::TABLE_DEPTH));
                1:       write_size('1);
                2:       write_size(stbs_pkg::SIZE_W'(stbs_pkg::TABLE_DEPTH + 1));
                default: write_size(stbs_pkg::SIZE_W'($urandom_range(stbs_pkg::TABLE_DEPTH / 2,
                                                                     stbs_pkg::TABLE_DEPTH)));
            endcase
            repeat (PHASE_SEARCHES) search(pick_key());
        end

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            run_phase(idle_mode_t'(phase % 4));
            phase++;
        end

        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("sorted_table_binary_search: match");
        else
            $display("sorted_table_binary_search: mismatch");
        $finish;
    end

endmodule
